// ===== src/plbcg_pkg.sv =====
// Package for the pixel level brightness/contrast/gamma block.
// Holds the fixed-point widths, the stage payload structs and the root table functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package plbcg_pkg;

  localparam int FIELD_W   = 16;
  localparam int FRAC_BITS = 15;
  localparam int ONE       = 1 << FRAC_BITS;

  // 4*c*c >> F, with c*c below 2^32
  localparam int CF_W   = 34 - FRAC_BITS;
  localparam int VCF_W  = FIELD_W + CF_W;
  localparam int LV_W   = VCF_W - FRAC_BITS + 2;
  localparam int D_W    = CF_W + 1;
  localparam int REM_W  = D_W + 1;
  // exponent 2^(F+32)/d with d >= ONE/4 stays at or below 2^34
  localparam int Q_W    = 35;
  localparam int M_W    = 31;
  localparam int NSH_W  = $clog2(FRAC_BITS + 1);
  localparam int L_W    = NSH_W + 32;
  localparam int P_W    = 40;
  localparam int ACC_W  = 33;
  localparam int LOG_STEPS = 32;

  typedef struct packed {
    logic             zero;
    logic [M_W-1:0]   m;
    logic [31:0]      frac;
    logic [NSH_W-1:0] nsh;
    logic [REM_W-1:0] rem;
    logic [D_W-1:0]   d;
    logic [Q_W-1:0]   q;
    logic [L_W-1:0]   lg;
  } core_t;

  typedef struct packed {
    logic             zero;
    logic [7:0]       ip;
    logic [31:0]      fp;
    logic [ACC_W-1:0] acc;
  } exp_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] r;
    logic [63:0] bv;
    rem = v;
    r   = '0;
    bv  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + bv) begin
        rem = rem - (r + bv);
        r   = (r >> 1) + bv;
      end else begin
        r = r >> 1;
      end
      bv = bv >> 2;
    end
    return r;
  endfunction

  // 2^(-2^-k) in Q32, by repeated exact square roots
  function automatic logic [31:0] root_q32(input int k);
    logic [63:0] r;
    r = isqrt64(64'd1 << 63);
    for (int j = 2; j <= 32; j++) begin
      if (j <= k) r = isqrt64({r[31:0], 32'd0});
    end
    return r[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/plbcg_if.sv =====
// Stream channel interfaces for the pixel level block: pixel input and level result.
// Valid/ready handshake; a beat moves when both are high. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface plbcg_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_value;
  logic [15:0] brightness_knob;
  logic [15:0] contrast_knob;
  logic [15:0] gamma_knob;
  modport source(output valid, pixel_value, brightness_knob, contrast_knob, gamma_knob,
                 input ready);
  modport sink(input valid, pixel_value, brightness_knob, contrast_knob, gamma_knob,
               output ready);
endinterface

interface plbcg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] level_out;
  modport source(output valid, level_out, input ready);
  modport sink(input valid, level_out, output ready);
endinterface

`default_nettype wire

// ===== src/plbcg_log_div.sv =====
// Log and exponent stages: 35 pipeline stages, each one restoring divide step for the
// gamma exponent, alongside normalize, 32 squaring steps of -log2 and the log assembly.
// Depends on plbcg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plbcg_log_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  plbcg_pkg::core_t   in_data,
  output logic               out_valid,
  output plbcg_pkg::core_t   out_data
);
  import plbcg_pkg::*;

  localparam int N_ST = Q_W;

  core_t st  [N_ST];
  logic  vld [N_ST];

  for (genvar i = 0; i < N_ST; i++) begin : g_st
    core_t            prev;
    core_t            dv;
    core_t            nxt;
    logic             pv;
    logic [REM_W-1:0] r2;

    if (i == 0) begin : g_first
      assign prev = in_data;
      assign pv   = in_valid;
    end else begin : g_chain
      assign prev = st[i-1];
      assign pv   = vld[i-1];
    end

    // one quotient bit per stage, MSB first
    always_comb begin
      r2 = {prev.rem[REM_W-2:0], 1'b0};
      dv = prev;
      if (r2 >= {1'b0, prev.d}) begin
        dv.rem = r2 - {1'b0, prev.d};
        dv.q   = {prev.q[Q_W-2:0], 1'b1};
      end else begin
        dv.rem = r2;
        dv.q   = {prev.q[Q_W-2:0], 1'b0};
      end
    end

    if (i == 0) begin : g_norm
      logic [FRAC_BITS:0] x;
      logic [NSH_W-1:0]   n;
      always_comb begin
        x = prev.m[FRAC_BITS:0];
        n = '0;
        for (int b = 0; b <= FRAC_BITS; b++) begin
          if (x[b]) n = NSH_W'(b);
        end
        nxt     = dv;
        nxt.nsh = NSH_W'(FRAC_BITS) - n;
        nxt.m   = M_W'(x) << (M_W - 1 - FRAC_BITS + int'(nxt.nsh));
      end
    end else if (i <= LOG_STEPS) begin : g_sq
      logic [2*M_W-1:0] sq;
      logic [31:0]      t;
      always_comb begin
        sq  = prev.m * prev.m;
        t   = sq[2*M_W-1:30];
        nxt = dv;
        if (t[31]) begin
          nxt.m    = t[31:1];
          nxt.frac = {prev.frac[30:0], 1'b1};
        end else begin
          nxt.m    = t[30:0];
          nxt.frac = {prev.frac[30:0], 1'b0};
        end
      end
    end else if (i == LOG_STEPS + 1) begin : g_lg
      always_comb begin
        nxt    = dv;
        nxt.lg = {dv.nsh, 32'd0} - L_W'(dv.frac);
      end
    end else begin : g_pass
      assign nxt = dv;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[i] <= nxt;
      end
    end
  end

  assign out_valid = vld[N_ST-1];
  assign out_data  = st[N_ST-1];

endmodule

`default_nettype wire

// ===== src/plbcg_exp.sv =====
// Power stages: 32 pipeline stages, each a conditional Q32 multiply by 2^(-2^-k)
// selected by one fraction bit of the scaled log. Depends on plbcg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plbcg_exp (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  plbcg_pkg::exp_t  in_data,
  output logic             out_valid,
  output plbcg_pkg::exp_t  out_data
);
  import plbcg_pkg::*;

  localparam int N_ST = 32;

  exp_t st  [N_ST];
  logic vld [N_ST];

  for (genvar i = 0; i < N_ST; i++) begin : g_st
    localparam logic [31:0] ROOT = root_q32(i + 1);
    exp_t                prev;
    exp_t                nxt;
    logic                pv;
    logic [ACC_W+31:0]   prod;

    if (i == 0) begin : g_first
      assign prev = in_data;
      assign pv   = in_valid;
    end else begin : g_chain
      assign prev = st[i-1];
      assign pv   = vld[i-1];
    end

    always_comb begin
      prod = prev.acc * ROOT;
      nxt  = prev;
      if (prev.fp[31-i]) nxt.acc = prod[ACC_W+31:32];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[i] <= nxt;
      end
    end
  end

  assign out_valid = vld[N_ST-1];
  assign out_data  = st[N_ST-1];

endmodule

`default_nettype wire

// ===== src/pixel_level_brightness_contrast_gamma.sv =====
// Pixel level filter: slope 4*c^2 about mid-gray, brightness offset, clamp to 0..1.0 and a
// gamma power 1/(3g^2+0.25), all Q1.15. Takes one pixel per clock while the skid entry is
// empty. The pipeline runs the 35-step exponent divider beside the 32-step log, followed
// by the 32-step power chain. A two-entry output (register plus skid) takes one more result
// while the output waits; once the skid is full the pipeline and the input stall.
// Depends on plbcg_pkg, plbcg_if, plbcg_log_div, plbcg_exp.
`timescale 1ns / 1ps
`default_nettype none

module pixel_level_brightness_contrast_gamma (
  input logic         clk,
  input logic         rst,
  plbcg_in_if.sink    pixel,
  plbcg_out_if.source level
);
  import plbcg_pkg::*;

  logic en;

  // front stage 1: squares
  logic               v1;
  logic [FIELD_W-1:0] val1;
  logic [FIELD_W-1:0] bri1;
  logic [31:0]        csq1;
  logic [31:0]        gsq1;
  // front stage 2: slope product, gamma denominator
  logic               v2;
  logic [VCF_W-1:0]   vcf2;
  logic [CF_W-1:0]    cf2;
  logic [FIELD_W-1:0] bri2;
  logic [D_W-1:0]     d2;
  logic [CF_W-1:0]    cf1;
  logic [33:0]        g3;
  // front stage 3: level and clamp
  logic               v3;
  core_t              c3;
  logic [LV_W-1:0]    pos;
  logic [LV_W-1:0]    neg;
  logic [LV_W-1:0]    diff;
  core_t              c3_next;

  logic               vc;
  core_t              cc;

  // product stages
  logic               vm1;
  logic               zm1;
  logic [63:0]        pll;
  logic [34:0]        plh;
  logic [35:0]        phl;
  logic [6:0]         phh;
  logic               vm2;
  exp_t               em2;
  logic [P_W-1:0]     p_sum;

  logic               ve;
  exp_t               ee;

  logic [ACC_W-1:0]           r;
  logic [ACC_W+FRAC_BITS:0]   rnd;
  logic [ACC_W+FRAC_BITS-32:0] res_w;
  logic [FIELD_W-1:0]         res;

  logic               out_v;
  logic [FIELD_W-1:0] out_d;
  logic               skid_v;
  logic [FIELD_W-1:0] skid_d;
  logic               push;

  assign en          = !skid_v;
  assign pixel.ready = en;

  assign cf1 = csq1[31:FRAC_BITS-2];
  assign g3  = {2'b00, gsq1} + {1'b0, gsq1, 1'b0};

  always_comb begin
    pos  = LV_W'(vcf2 >> FRAC_BITS) + LV_W'(bri2);
    neg  = LV_W'(cf2 >> 1);
    diff = pos - neg;
    c3_next      = '0;
    c3_next.d    = d2;
    c3_next.rem  = REM_W'(1) << (FRAC_BITS - 3);
    c3_next.zero = (pos <= neg);
    if (pos <= neg) begin
      c3_next.m = M_W'(1);
    end else if (diff >= LV_W'(ONE)) begin
      c3_next.m = M_W'(ONE);
    end else begin
      c3_next.m = M_W'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= pixel.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val1 <= pixel.pixel_value;
      bri1 <= pixel.brightness_knob;
      csq1 <= pixel.contrast_knob * pixel.contrast_knob;
      gsq1 <= pixel.gamma_knob * pixel.gamma_knob;
      vcf2 <= val1 * cf1;
      cf2  <= cf1;
      bri2 <= bri1;
      d2   <= D_W'(g3 >> FRAC_BITS) + D_W'(ONE >> 2);
      c3   <= c3_next;
    end
  end

  plbcg_log_div u_log_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .in_data   (c3),
    .out_valid (vc),
    .out_data  (cc)
  );

  // log times exponent, Q32, split into 32-bit partial products
  assign p_sum = P_W'({phh, 32'd0}) + P_W'(plh) + P_W'(phl) + P_W'(pll[63:32]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vm1 <= 1'b0;
      vm2 <= 1'b0;
    end else if (en) begin
      vm1 <= vc;
      vm2 <= vm1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zm1      <= cc.zero;
      pll      <= cc.lg[31:0] * cc.q[31:0];
      plh      <= cc.lg[31:0] * cc.q[Q_W-1:32];
      phl      <= cc.lg[L_W-1:32] * cc.q[31:0];
      phh      <= cc.lg[L_W-1:32] * cc.q[Q_W-1:32];
      em2.zero <= zm1;
      em2.ip   <= p_sum[P_W-1:32];
      em2.fp   <= p_sum[31:0];
      em2.acc  <= ACC_W'(1) << 32;
    end
  end

  plbcg_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vm2),
    .in_data   (em2),
    .out_valid (ve),
    .out_data  (ee)
  );

  // integer part of the scaled log shifts the power; round half up to Q1.15
  always_comb begin
    r     = ee.acc >> ee.ip;
    rnd   = ((ACC_W+FRAC_BITS+1)'(r) << FRAC_BITS) + ((ACC_W+FRAC_BITS+1)'(1) << 31);
    res_w = rnd[ACC_W+FRAC_BITS:32];
    if (ee.zero) begin
      res = '0;
    end else if (res_w > (ACC_W+FRAC_BITS-31)'(ONE)) begin
      res = FIELD_W'(ONE);
    end else begin
      res = FIELD_W'(res_w);
    end
  end

  assign push = ve && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (out_v && level.ready) begin
      if (skid_v) begin
        out_d  <= skid_d;
        skid_v <= 1'b0;
      end else if (push) begin
        out_d <= res;
      end else begin
        out_v <= 1'b0;
      end
    end else if (!out_v) begin
      if (push) begin
        out_v <= 1'b1;
        out_d <= res;
      end
    end else if (push) begin
      skid_v <= 1'b1;
      skid_d <= res;
    end
  end

  assign level.valid     = out_v;
  assign level.level_out = out_d;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid holds a beat while output register is empty");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_v |-> (out_d <= FIELD_W'(ONE)))
    else $error("level above full scale");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(ve))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire
